[hdl/acde_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acde_pkg: shared definitions of the attribute cell draw engine
// Command codes, field widths, the decoded operation type and width helpers
// used by the top level, the front end and the back end.
// ----------------------------------------------------------------------------
package acde_pkg;

  // Field widths of one input item
  localparam int CMD_W    = 3;
  localparam int XY_W     = 5;
  localparam int COLOUR_W = 8;

  // Default store geometry
  localparam int COLUMNS_DEF = 32;
  localparam int ROWS_DEF    = 24;

  // Segment list of one decoded command
  localparam int SEG_N = 4;
  localparam int CNT_W = XY_W + 1;   // up to 2**XY_W cells per segment

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_PLOT   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SQUARE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_RUN5   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_BOX    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_HLINE  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_SWAP   = 3'd5;
  localparam logic [CMD_W-1:0] CMD_READ   = 3'd6;

  // Run length of the run5 command
  localparam int RUN5_LEN = 5;

  // Operation class handed from front to back
  typedef enum logic [1:0] {
    OP_DRAW,
    OP_SWAP,
    OP_READ,
    OP_NOP
  } op_e;

  // Back end status seen by the front end and the top level
  typedef struct packed {
    logic clearing;
    logic busy;
  } back_stat_t;

  // Bits of a linear address including headroom for runs past the store
  function automatic int addr_bits(input int columns);
    return $clog2((2 ** XY_W) * columns + 2 * (2 ** XY_W));
  endfunction

  // Bits of one packed command descriptor
  function automatic int desc_bits(input int aw);
    return 2 + SEG_N * (aw + 1 + CNT_W) + 2 * COLOUR_W;
  endfunction

endpackage

[hdl/attribute_cell_draw_engine_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// attribute_cell_draw_engine_core: attribute cell draw engine top level
// Colour attribute store with drawing, swap and read-back commands.
// ----------------------------------------------------------------------------
// After reset the engine zeroes its COLUMNS x ROWS store and takes no item
// until that pass ends. Items are then decoded on entry and wait in a
// two-entry queue, so up to two further items are taken while one runs and
// its result sits in the output register. Execution is bound by the single
// write port of the store: a drawing command writes one cell per cycle
// along its segments, swap sweeps every cell of the store, and read fetches
// one cell. Each item gives exactly one result: the cell value for read,
// zero for all other commands.
// ----------------------------------------------------------------------------
module attribute_cell_draw_engine_core
  import acde_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [CMD_W-1:0]    command_i,
  input  logic [XY_W-1:0]     x_start_i,
  input  logic [XY_W-1:0]     y_start_i,
  input  logic [XY_W-1:0]     x_end_i,
  input  logic [XY_W-1:0]     y_end_i,
  input  logic [COLOUR_W-1:0] colour_i,
  input  logic [COLOUR_W-1:0] other_colour_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [COLOUR_W-1:0] read_value_o
);

  localparam int DescW = desc_bits(addr_bits(COLUMNS));

  logic             q_push, q_pop, q_full, q_empty;
  logic [DescW-1:0] q_in, q_out;
  back_stat_t       stat;

  // Decoder
  acde_front #(
    .COLUMNS (COLUMNS)
  ) u_front (
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .x_start_i      (x_start_i),
    .y_start_i      (y_start_i),
    .x_end_i        (x_end_i),
    .y_end_i        (y_end_i),
    .colour_i       (colour_i),
    .other_colour_i (other_colour_i),
    .full_i         (q_full),
    .stat_i         (stat),
    .push_o         (q_push),
    .desc_o         (q_in)
  );

  // Command queue
  acde_queue #(
    .Width (DescW),
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (q_out)
  );

  // Drawing engine
  acde_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .desc_i       (q_out),
    .empty_i      (q_empty),
    .pop_o        (q_pop),
    .stat_o       (stat),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .read_value_o (read_value_o)
  );

  // Queue never overflows
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_push |-> (!q_full || q_pop))
    else $error("command queue overflow");

  // Back end only pops a queued command
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> !q_empty)
    else $error("pop from empty command queue");

  // A result only appears after a command was executed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   $rose(out_valid_o) |-> $past(stat.busy))
    else $error("result without an executed command");

  // Nothing enters while the store is being cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni) stat.clearing |-> !q_pop)
    else $error("command started during store clearing");

endmodule

[hdl/acde_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acde_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered and holds
// until the next read.
// ----------------------------------------------------------------------------
module acde_ram #(
  parameter int Width = 8,
  parameter int Depth = 768
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/acde_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acde_queue: short command queue
// Small register FIFO that decouples the decoding front end from the
// drawing back end.
// ----------------------------------------------------------------------------
module acde_queue #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [Width-1:0] data_o
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] entry_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign data_o  = entry_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

[hdl/acde_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acde_front: command decoder
// Accepts command items, computes the linear base addresses and turns each
// command into a list of up to four straight segments for the back end.
// ----------------------------------------------------------------------------
module acde_front
  import acde_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF
) (
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic [CMD_W-1:0]                        command_i,
  input  logic [XY_W-1:0]                         x_start_i,
  input  logic [XY_W-1:0]                         y_start_i,
  input  logic [XY_W-1:0]                         x_end_i,
  input  logic [XY_W-1:0]                         y_end_i,
  input  logic [COLOUR_W-1:0]                     colour_i,
  input  logic [COLOUR_W-1:0]                     other_colour_i,
  input  logic                                    full_i,
  input  back_stat_t                              stat_i,
  output logic                                    push_o,
  output logic [desc_bits(addr_bits(COLUMNS))-1:0] desc_o
);

  localparam int AddrW = addr_bits(COLUMNS);

  typedef struct packed {
    logic [AddrW-1:0] base;
    logic             col_step;   // step one row instead of one cell
    logic [CNT_W-1:0] count;
  } seg_t;

  typedef struct packed {
    op_e                    op;
    seg_t [SEG_N-1:0]       seg;
    logic [COLOUR_W-1:0]    colour;
    logic [COLOUR_W-1:0]    other;
  } desc_t;

  logic [AddrW-1:0] row_top, row_bot;
  logic [AddrW-1:0] a_addr, bot_addr, rgt_addr;
  logic [CNT_W-1:0] h_cnt, v_cnt;
  desc_t            desc;

  // No item is taken while the store is being cleared
  assign in_ready_o = !full_i && !stat_i.clearing;
  assign push_o     = in_valid_i && in_ready_o;

  // Corner addresses
  assign row_top  = AddrW'(y_start_i) * AddrW'(COLUMNS);
  assign row_bot  = AddrW'(y_end_i) * AddrW'(COLUMNS);
  assign a_addr   = row_top + AddrW'(x_start_i);
  assign bot_addr = row_bot + AddrW'(x_start_i);
  assign rgt_addr = row_top + AddrW'(x_end_i);

  // Span lengths, zero for an empty range
  assign h_cnt = (x_end_i >= x_start_i) ? CNT_W'(x_end_i - x_start_i) + CNT_W'(1) : '0;
  assign v_cnt = (y_end_i >= y_start_i) ? CNT_W'(y_end_i - y_start_i) + CNT_W'(1) : '0;

  // Segment list per command
  always_comb begin
    desc        = '0;
    desc.colour = colour_i;
    desc.other  = other_colour_i;
    desc.op     = OP_DRAW;
    unique case (command_i)
      CMD_PLOT: begin
        desc.seg[0] = '{base: a_addr, col_step: 1'b0, count: CNT_W'(1)};
      end
      CMD_SQUARE: begin
        desc.seg[0] = '{base: a_addr, col_step: 1'b0, count: CNT_W'(2)};
        desc.seg[1] = '{base: a_addr + AddrW'(COLUMNS), col_step: 1'b0, count: CNT_W'(2)};
      end
      CMD_RUN5: begin
        desc.seg[0] = '{base: a_addr, col_step: 1'b0, count: CNT_W'(RUN5_LEN)};
      end
      CMD_BOX: begin
        desc.seg[0] = '{base: a_addr,   col_step: 1'b0, count: h_cnt};
        desc.seg[1] = '{base: bot_addr, col_step: 1'b0, count: h_cnt};
        desc.seg[2] = '{base: a_addr,   col_step: 1'b1, count: v_cnt};
        desc.seg[3] = '{base: rgt_addr, col_step: 1'b1, count: v_cnt};
      end
      CMD_HLINE: begin
        desc.seg[0] = '{base: a_addr, col_step: 1'b0, count: h_cnt};
      end
      CMD_SWAP: begin
        desc.op = OP_SWAP;
      end
      CMD_READ: begin
        desc.op          = OP_READ;
        desc.seg[0].base = a_addr;
      end
      default: begin
        desc.op = OP_NOP;
      end
    endcase
  end

  assign desc_o = desc;

endmodule

[hdl/acde_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acde_back: drawing engine
// Clears the attribute store after reset, then executes decoded commands
// one at a time: walks segments for drawing, sweeps the store for swap,
// reads one cell for read, and holds the result in an output register.
// ----------------------------------------------------------------------------
module acde_back
  import acde_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic [desc_bits(addr_bits(COLUMNS))-1:0] desc_i,
  input  logic                                     empty_i,
  output logic                                     pop_o,
  output back_stat_t                               stat_o,
  output logic                                     out_valid_o,
  input  logic                                     out_ready_i,
  output logic [COLOUR_W-1:0]                      read_value_o
);

  localparam int AddrW   = addr_bits(COLUMNS);
  localparam int CmpW    = AddrW + 1;
  localparam int Cells   = COLUMNS * ROWS;
  localparam int AW      = $clog2(Cells);
  localparam int IdxW    = $clog2(Cells + 1);
  localparam int SegIdxW = $clog2(SEG_N);

  typedef struct packed {
    logic [AddrW-1:0] base;
    logic             col_step;
    logic [CNT_W-1:0] count;
  } seg_t;

  typedef struct packed {
    op_e                    op;
    seg_t [SEG_N-1:0]       seg;
    logic [COLOUR_W-1:0]    colour;
    logic [COLOUR_W-1:0]    other;
  } desc_t;

  // State codes
  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_DRAW  = 3'd2;
  localparam logic [2:0] ST_SWAP  = 3'd3;
  localparam logic [2:0] ST_READ  = 3'd4;
  localparam logic [2:0] ST_RWAIT = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  logic [2:0]          state_q, state_d;
  desc_t               desc_q, desc_d;
  desc_t               head;
  logic [SegIdxW-1:0]  seg_q, seg_d, seg_nx;
  logic [CNT_W-1:0]    k_q, k_d;
  logic [AddrW-1:0]    addr_q, addr_d;
  logic [IdxW-1:0]     idx_q, idx_d;
  logic                pend_q, pend_d;
  logic [AW-1:0]       paddr_q, paddr_d;
  logic [COLOUR_W-1:0] res_q, res_d;
  logic                out_valid_q, out_valid_d;
  logic [COLOUR_W-1:0] out_data_q, out_data_d;

  seg_t                cur_seg;
  logic [AddrW-1:0]    stride;
  logic                in_range;
  logic                we, re;
  logic [AW-1:0]       waddr, raddr;
  logic [COLOUR_W-1:0] wdata, rdata;

  assign head     = desc_t'(desc_i);
  assign cur_seg  = desc_q.seg[seg_q];
  assign seg_nx   = seg_q + 1'b1;
  assign stride   = cur_seg.col_step ? AddrW'(COLUMNS) : AddrW'(1);
  assign in_range = CmpW'(addr_q) < CmpW'(Cells);

  // Attribute store
  acde_ram #(
    .Width (COLOUR_W),
    .Depth (Cells)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Sequencer
  always_comb begin
    state_d     = state_q;
    desc_d      = desc_q;
    seg_d       = seg_q;
    k_d         = k_q;
    addr_d      = addr_q;
    idx_d       = idx_q;
    pend_d      = pend_q;
    paddr_d     = paddr_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    pop_o       = 1'b0;
    we          = 1'b0;
    waddr       = AW'(addr_q);
    wdata       = desc_q.colour;
    re          = 1'b0;
    raddr       = AW'(addr_q);

    unique case (state_q)
      // Zero the store one cell per cycle
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = AW'(idx_q);
        wdata = '0;
        if (idx_q == IdxW'(Cells - 1)) begin
          state_d = ST_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      // Take the next command from the queue
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          desc_d  = head;
          seg_d   = '0;
          k_d     = '0;
          addr_d  = head.seg[0].base;
          idx_d   = '0;
          pend_d  = 1'b0;
          res_d   = '0;
          unique case (head.op)
            OP_DRAW: state_d = ST_DRAW;
            OP_SWAP: state_d = ST_SWAP;
            OP_READ: state_d = ST_READ;
            OP_NOP:  state_d = ST_DONE;
            default: state_d = ST_DONE;
          endcase
        end
      end

      // One cell per cycle along the current segment
      ST_DRAW: begin
        if (k_q != cur_seg.count) begin
          we     = in_range;
          addr_d = addr_q + stride;
          k_d    = k_q + 1'b1;
        end else if (seg_q == SegIdxW'(SEG_N - 1)) begin
          state_d = ST_DONE;
        end else begin
          seg_d  = seg_nx;
          k_d    = '0;
          addr_d = desc_q.seg[seg_nx].base;
        end
      end

      // Read cell idx, rewrite the cell read in the previous cycle
      ST_SWAP: begin
        if (idx_q != IdxW'(Cells)) begin
          re    = 1'b1;
          raddr = AW'(idx_q);
          idx_d = idx_q + 1'b1;
        end
        pend_d  = (idx_q != IdxW'(Cells));
        paddr_d = AW'(idx_q);
        if (pend_q) begin
          waddr = paddr_q;
          if (rdata == desc_q.colour) begin
            we    = 1'b1;
            wdata = desc_q.other;
          end else if (rdata == desc_q.other) begin
            we    = 1'b1;
            wdata = desc_q.colour;
          end
        end
        if (idx_q == IdxW'(Cells) && !pend_q) begin
          state_d = ST_DONE;
        end
      end

      ST_READ: begin
        re      = in_range;
        state_d = ST_RWAIT;
      end

      ST_RWAIT: begin
        res_d   = in_range ? rdata : '0;
        state_d = ST_DONE;
      end

      // Hand the result to the output register
      ST_DONE: begin
        if (!out_valid_d) begin
          out_valid_d = 1'b1;
          out_data_d  = res_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      seg_q       <= '0;
      k_q         <= '0;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      seg_q       <= seg_d;
      k_q         <= k_d;
      idx_q       <= idx_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    desc_q     <= desc_d;
    addr_q     <= addr_d;
    paddr_q    <= paddr_d;
    res_q      <= res_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o     = out_valid_q;
  assign read_value_o    = out_data_q;
  assign stat_o.clearing = (state_q == ST_CLEAR);
  assign stat_o.busy     = (state_q != ST_IDLE) && (state_q != ST_CLEAR);

endmodule

[tb/sv/attribute_cell_draw_engine_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// attribute_cell_draw_engine_checker: scoreboard of the attribute draw engine
// Watches both channels, redraws every accepted command into its own copy of
// the attribute store and compares each result item with the oldest expected
// read byte. Hands the mismatch count and the number of open items upward.
// ----------------------------------------------------------------------------
module attribute_cell_draw_engine_checker
  import acde_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic [CMD_W-1:0]    command_i,
  input  logic [XY_W-1:0]     x_start_i,
  input  logic [XY_W-1:0]     y_start_i,
  input  logic [XY_W-1:0]     x_end_i,
  input  logic [XY_W-1:0]     y_end_i,
  input  logic [COLOUR_W-1:0] colour_i,
  input  logic [COLOUR_W-1:0] other_colour_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic [COLOUR_W-1:0] read_value_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  localparam int CELLS = COLUMNS * ROWS;

  // Shadow of the attribute store and the read bytes still owed by the block
  logic [COLOUR_W-1:0] shadow_cells [CELLS];
  logic [COLOUR_W-1:0] expected_reads [$];
  logic [COLOUR_W-1:0] wanted;
  int                  mismatches;

  // Writes beyond the last cell fall off the store
  function automatic void paint_cell(input int addr, input logic [COLOUR_W-1:0] col);
    if (addr < CELLS) shadow_cells[addr] = col;
  endfunction

  // Applies one command to the shadow store and returns its read byte
  function automatic logic [COLOUR_W-1:0] draw_command(
    input logic [CMD_W-1:0]    cmd,
    input logic [XY_W-1:0]     xs,
    input logic [XY_W-1:0]     ys,
    input logic [XY_W-1:0]     xe,
    input logic [XY_W-1:0]     ye,
    input logic [COLOUR_W-1:0] col,
    input logic [COLOUR_W-1:0] oth
  );
    int                  base;
    int                  bottom;
    int                  right;
    logic [COLOUR_W-1:0] value;
    base   = int'(ys) * COLUMNS + int'(xs);
    bottom = int'(ye) * COLUMNS + int'(xs);
    right  = int'(ys) * COLUMNS + int'(xe);
    value  = '0;
    case (cmd)
      CMD_PLOT: begin
        paint_cell(base, col);
      end
      CMD_SQUARE: begin
        paint_cell(base, col);
        paint_cell(base + 1, col);
        paint_cell(base + COLUMNS, col);
        paint_cell(base + COLUMNS + 1, col);
      end
      CMD_RUN5: begin
        for (int k = 0; k < RUN5_LEN; k++) paint_cell(base + k, col);
      end
      CMD_BOX: begin
        // top and bottom edges, then left and right edges; each may be empty
        if (xe >= xs) begin
          for (int k = 0; k <= int'(xe) - int'(xs); k++) begin
            paint_cell(base + k, col);
            paint_cell(bottom + k, col);
          end
        end
        if (ye >= ys) begin
          for (int k = 0; k <= int'(ye) - int'(ys); k++) begin
            paint_cell(base + k * COLUMNS, col);
            paint_cell(right + k * COLUMNS, col);
          end
        end
      end
      CMD_HLINE: begin
        if (xe >= xs) begin
          for (int k = 0; k <= int'(xe) - int'(xs); k++) paint_cell(base + k, col);
        end
      end
      CMD_SWAP: begin
        for (int k = 0; k < CELLS; k++) begin
          if (shadow_cells[k] == col) shadow_cells[k] = oth;
          else if (shadow_cells[k] == oth) shadow_cells[k] = col;
        end
      end
      CMD_READ: begin
        if (base < CELLS) value = shadow_cells[base];
      end
      default: begin
        // unused code: store untouched, result zero
      end
    endcase
    return value;
  endfunction

  // Result side first: a result never belongs to an item taken at the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (shadow_cells[i]) shadow_cells[i] = '0;
      expected_reads.delete();
      mismatches = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_reads.size() == 0) begin
          $error("read_value: expected none, actual 8'h%02h", read_value_i);
          mismatches++;
        end else begin
          wanted = expected_reads.pop_front();
          if (read_value_i !== wanted) begin
            $error("read_value: expected 8'h%02h, actual 8'h%02h", wanted, read_value_i);
            mismatches++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_reads.push_back(draw_command(command_i, x_start_i, y_start_i,
                                              x_end_i, y_end_i, colour_i,
                                              other_colour_i));
      end
      fail_count_o <= mismatches;
      pending_o    <= expected_reads.size();
    end
  end

endmodule

[tb/sv/attribute_cell_draw_engine_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// attribute_cell_draw_engine_core_tb: testbench of the attribute draw engine
// Drives directed corner commands, then random drawing, swap and read-back
// traffic with bursty stalls on both channels; the checker beside the block
// predicts every read byte and the top reports the verdict.
// ----------------------------------------------------------------------------
module attribute_cell_draw_engine_core_tb;
  import acde_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
  localparam int RANDOM_ITEMS = 758;
  localparam int CALM_ITEMS   = 60;
  localparam int DRAIN_CYCLES = 50;
  localparam int X_MAX        = 31;
  localparam int Y_MAX        = 23;

  logic                clk          = 1'b0;
  logic                rst_n        = 1'b0;
  logic                in_valid     = 1'b0;
  logic                in_ready;
  logic [CMD_W-1:0]    command      = '0;
  logic [XY_W-1:0]     x_start      = '0;
  logic [XY_W-1:0]     y_start      = '0;
  logic [XY_W-1:0]     x_end        = '0;
  logic [XY_W-1:0]     y_end        = '0;
  logic [COLOUR_W-1:0] colour       = '0;
  logic [COLOUR_W-1:0] other_colour = '0;
  logic                out_valid;
  logic                out_ready    = 1'b0;
  logic [COLOUR_W-1:0] read_value;

  int fail_count;
  int pending;

  // Stall control: density and calm flag shared by both sides, burst counter of the receiver
  int idle_pct   = 0;
  bit calm       = 1'b0;
  int stall_left = 0;

  // Recently drawn cells, so that reads land on painted areas
  logic [XY_W-1:0]     recent_x [8] = '{default: '0};
  logic [XY_W-1:0]     recent_y [8] = '{default: '0};
  int                  recent_idx = 0;
  logic [COLOUR_W-1:0] palette  [4] = '{8'h00, 8'h38, 8'hC7, 8'hFF};

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  attribute_cell_draw_engine_core u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .command_i      (command),
    .x_start_i      (x_start),
    .y_start_i      (y_start),
    .x_end_i        (x_end),
    .y_end_i        (y_end),
    .colour_i       (colour),
    .other_colour_i (other_colour),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .read_value_o   (read_value)
  );

  attribute_cell_draw_engine_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .command_i      (command),
    .x_start_i      (x_start),
    .y_start_i      (y_start),
    .x_end_i        (x_end),
    .y_end_i        (y_end),
    .colour_i       (colour),
    .other_colour_i (other_colour),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .read_value_i   (read_value),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  // Receiver stalls: random bursts, no new ones once the run calms down
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 99) < idle_pct) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 7);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Presents one item, optionally after a sender gap, and waits for its accept
  task automatic send_item(
    input logic [CMD_W-1:0]    cmd,
    input logic [XY_W-1:0]     xs,
    input logic [XY_W-1:0]     ys,
    input logic [XY_W-1:0]     xe,
    input logic [XY_W-1:0]     ye,
    input logic [COLOUR_W-1:0] col,
    input logic [COLOUR_W-1:0] oth
  );
    if (!calm && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    command      <= cmd;
    x_start      <= xs;
    y_start      <= ys;
    x_end        <= xe;
    y_end        <= ye;
    colour       <= col;
    other_colour <= oth;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Holds the sender off until every owed result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [XY_W-1:0] pick_coord(input int hi);
    if ($urandom_range(0, 9) == 0) return XY_W'(($urandom_range(0, 1) != 0) ? hi : 0);
    return XY_W'($urandom_range(0, hi));
  endfunction

  function automatic logic [COLOUR_W-1:0] pick_colour();
    if ($urandom_range(0, 9) < 6) return palette[$urandom_range(0, 3)];
    return COLOUR_W'($urandom_range(0, 255));
  endfunction

  // One random command; mostly draws and reads, with occasional swaps and rare unused codes
  task automatic random_item();
    int                  sel;
    int                  slot;
    logic [CMD_W-1:0]    cmd;
    logic [XY_W-1:0]     xs;
    logic [XY_W-1:0]     ys;
    logic [XY_W-1:0]     xe;
    logic [XY_W-1:0]     ye;
    logic [XY_W-1:0]     tmp;
    logic [COLOUR_W-1:0] col;
    logic [COLOUR_W-1:0] oth;
    sel = $urandom_range(0, 99);
    xs  = pick_coord(X_MAX);
    ys  = pick_coord(Y_MAX);
    xe  = pick_coord(X_MAX);
    ye  = pick_coord(Y_MAX);
    col = pick_colour();
    oth = pick_colour();
    if (sel < 14)      cmd = CMD_PLOT;
    else if (sel < 24) cmd = CMD_SQUARE;
    else if (sel < 34) cmd = CMD_RUN5;
    else if (sel < 42) cmd = CMD_BOX;
    else if (sel < 54) cmd = CMD_HLINE;
    else if (sel < 59) cmd = CMD_SWAP;
    else if (sel < 98) cmd = CMD_READ;
    else               cmd = CMD_UNUSED;
    // ranges mostly ordered; a fifth stay as drawn, often empty
    if ($urandom_range(0, 4) != 0) begin
      if (xe < xs) begin
        tmp = xe;
        xe  = xs;
        xs  = tmp;
      end
      if (ye < ys) begin
        tmp = ye;
        ye  = ys;
        ys  = tmp;
      end
    end
    if (cmd == CMD_READ && $urandom_range(0, 1) != 0) begin
      slot = $urandom_range(0, 7);
      xs   = recent_x[slot];
      ys   = recent_y[slot];
    end else if (cmd != CMD_READ && cmd != CMD_SWAP && cmd != CMD_UNUSED) begin
      recent_x[recent_idx] = xs;
      recent_y[recent_idx] = ys;
      recent_idx = (recent_idx + 1) % 8;
    end
    send_item(cmd, xs, ys, xe, ye, col, oth);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed corners
    idle_pct = 20;
    send_item(CMD_READ,   5'd0,  5'd0,  5'd0,  5'd0,  8'h00, 8'h00);
    send_item(CMD_PLOT,   5'd0,  5'd0,  5'd0,  5'd0,  8'hFF, 8'h00);
    send_item(CMD_PLOT,   5'd31, 5'd23, 5'd31, 5'd23, 8'hA5, 8'h5A);
    send_item(CMD_READ,   5'd31, 5'd23, 5'd0,  5'd0,  8'h00, 8'h00);
    // square and run5 hanging off the last cell: the excess is dropped
    send_item(CMD_SQUARE, 5'd31, 5'd23, 5'd0,  5'd0,  8'h66, 8'h00);
    send_item(CMD_RUN5,   5'd30, 5'd23, 5'd0,  5'd0,  8'h3C, 8'h00);
    // runs wrapping into the next row
    send_item(CMD_SQUARE, 5'd31, 5'd5,  5'd0,  5'd0,  8'h5A, 8'h00);
    send_item(CMD_RUN5,   5'd29, 5'd2,  5'd0,  5'd0,  8'h24, 8'h00);
    send_item(CMD_READ,   5'd0,  5'd6,  5'd0,  5'd0,  8'h00, 8'h00);
    send_item(CMD_READ,   5'd1,  5'd3,  5'd0,  5'd0,  8'h00, 8'h00);
    send_item(CMD_HLINE,  5'd0,  5'd10, 5'd31, 5'd0,  8'h81, 8'h00);
    send_item(CMD_HLINE,  5'd20, 5'd11, 5'd5,  5'd0,  8'h11, 8'h00);
    send_item(CMD_BOX,    5'd2,  5'd3,  5'd9,  5'd12, 8'h42, 8'h00);
    send_item(CMD_BOX,    5'd10, 5'd1,  5'd4,  5'd6,  8'h17, 8'h00);
    send_item(CMD_BOX,    5'd12, 5'd20, 5'd18, 5'd14, 8'h71, 8'h00);
    send_item(CMD_BOX,    5'd0,  5'd0,  5'd31, 5'd23, 8'h7E, 8'h00);
    send_item(CMD_SWAP,   5'd0,  5'd0,  5'd0,  5'd0,  8'h7E, 8'h81);
    send_item(CMD_SWAP,   5'd0,  5'd0,  5'd0,  5'd0,  8'h42, 8'h42);
    send_item(CMD_SWAP,   5'd0,  5'd0,  5'd0,  5'd0,  8'h00, 8'hFF);
    send_item(CMD_UNUSED, 5'd31, 5'd23, 5'd31, 5'd23, 8'hFF, 8'hFF);
    send_item(CMD_READ,   5'd0,  5'd0,  5'd0,  5'd0,  8'h00, 8'h00);
    send_item(CMD_READ,   5'd31, 5'd10, 5'd0,  5'd0,  8'h00, 8'h00);
    send_item(CMD_READ,   5'd9,  5'd12, 5'd0,  5'd0,  8'h00, 8'h00);
    send_item(CMD_READ,   5'd0,  5'd23, 5'd0,  5'd0,  8'h00, 8'h00);
    wait_drained();

    // Random traffic, stall density changing every hundred items
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 100 == 0) begin
        case ($urandom_range(0, 2))
          0:       idle_pct = 0;
          1:       idle_pct = 10;
          default: idle_pct = 35;
        endcase
      end
      if (i == RANDOM_ITEMS / 2) wait_drained();
      if (i == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
      random_item();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #50_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
